// ===== hdl/tbsw_pkg.sv =====
// shared types, constants and microcode table for the two band stereo width unit
`timescale 1ns / 1ps

package tbsw_pkg;

   // sample and register geometry
   localparam int SAMPLE_BITS    = 24;
   localparam int SAMPLE_MAX     = (2 ** (SAMPLE_BITS - 1)) - 1;
   localparam int COEFF_BITS_DEF = 16;
   localparam int WIDTH_FRAC     = 15;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_DATA_BITS-1:0] WIDTH_MAX   = 16'd32768;
   localparam logic [CSR_DATA_BITS-1:0] COEFF_RESET = 16'd4506;
   localparam logic [CSR_DATA_BITS-1:0] WIDTH_RESET = 16'd16384;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_COEFF      = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WIDTH_LOW  = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WIDTH_HIGH = 8'd2;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_in;
      logic signed [SAMPLE_BITS-1:0] right_in;
   } req_word_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_out;
      logic signed [SAMPLE_BITS-1:0] right_out;
   } rsp_word_type;

   // microcode fields
   localparam int PC_BITS = 5;

   typedef enum logic [1:0] {
      COND_NEXT = 2'd0,
      COND_REQ  = 2'd1,
      COND_RSP  = 2'd2
   } cond_type;

   typedef enum logic [2:0] {
      DST_NONE = 3'd0,
      DST_A    = 3'd1,
      DST_LPL  = 3'd2,
      DST_LPR  = 3'd3,
      DST_SUM  = 3'd4
   } dst_type;

   typedef enum logic [2:0] {
      SRC_ZERO = 3'd0,
      SRC_XL   = 3'd1,
      SRC_XR   = 3'd2,
      SRC_LPL  = 3'd3,
      SRC_LPR  = 3'd4,
      SRC_A    = 3'd5,
      SRC_SUM  = 3'd6,
      SRC_ACC  = 3'd7
   } src_type;

   typedef enum logic [1:0] {
      MUL_NONE = 2'd0,
      MUL_HI   = 2'd1,
      MUL_LO   = 2'd2
   } mul_type;

   typedef enum logic [1:0] {
      MSEL_COEFF = 2'd0,
      MSEL_WLO   = 2'd1,
      MSEL_WHI   = 2'd2
   } msel_type;

   typedef enum logic {
      SHIFT_COEFF = 1'b0,
      SHIFT_WIDTH = 1'b1
   } shift_type;

   typedef enum logic [1:0] {
      FIN_NONE  = 2'd0,
      FIN_LEFT  = 2'd1,
      FIN_RIGHT = 2'd2
   } fin_type;

   typedef struct packed {
      cond_type            cond;
      logic [PC_BITS-1:0]  target;
      dst_type             dst;
      src_type             sa;
      src_type             sb;
      logic                sub;
      mul_type             mul;
      msel_type            msel;
      shift_type           shift;
      fin_type             fin;
   } ucode_word_type;

   typedef struct packed {
      ucode_word_type uword;
      logic           load;
      logic           emit;
   } seq_ctrl_type;

   // program addresses
   localparam logic [PC_BITS-1:0] UC_IDLE   = 5'd0;
   localparam logic [PC_BITS-1:0] UC_L_DIFF = 5'd1;
   localparam logic [PC_BITS-1:0] UC_L_MHI  = 5'd2;
   localparam logic [PC_BITS-1:0] UC_L_MLO  = 5'd3;
   localparam logic [PC_BITS-1:0] UC_L_UPD  = 5'd4;
   localparam logic [PC_BITS-1:0] UC_R_DIFF = 5'd5;
   localparam logic [PC_BITS-1:0] UC_R_MHI  = 5'd6;
   localparam logic [PC_BITS-1:0] UC_R_MLO  = 5'd7;
   localparam logic [PC_BITS-1:0] UC_R_UPD  = 5'd8;
   localparam logic [PC_BITS-1:0] UC_SL     = 5'd9;
   localparam logic [PC_BITS-1:0] UC_SL_MHI = 5'd10;
   localparam logic [PC_BITS-1:0] UC_SL_MLO = 5'd11;
   localparam logic [PC_BITS-1:0] UC_TL     = 5'd12;
   localparam logic [PC_BITS-1:0] UC_SH_A   = 5'd13;
   localparam logic [PC_BITS-1:0] UC_SH_B   = 5'd14;
   localparam logic [PC_BITS-1:0] UC_SH_C   = 5'd15;
   localparam logic [PC_BITS-1:0] UC_SH_MHI = 5'd16;
   localparam logic [PC_BITS-1:0] UC_SH_MLO = 5'd17;
   localparam logic [PC_BITS-1:0] UC_TH     = 5'd18;
   localparam logic [PC_BITS-1:0] UC_BASE   = 5'd19;
   localparam logic [PC_BITS-1:0] UC_FIN_L  = 5'd20;
   localparam logic [PC_BITS-1:0] UC_FIN_R  = 5'd21;
   localparam logic [PC_BITS-1:0] UC_EMIT   = 5'd22;

   // control store
   function automatic ucode_word_type ucode_rom(input logic [PC_BITS-1:0] step);
      ucode_word_type w;
      w.cond   = COND_NEXT;
      w.target = step + PC_BITS'(1);
      w.dst    = DST_NONE;
      w.sa     = SRC_ZERO;
      w.sb     = SRC_ZERO;
      w.sub    = 1'b0;
      w.mul    = MUL_NONE;
      w.msel   = MSEL_COEFF;
      w.shift  = SHIFT_COEFF;
      w.fin    = FIN_NONE;
      case (step)
         UC_IDLE: begin
            w.cond = COND_REQ;
         end
         UC_L_DIFF: begin
            w.dst = DST_A; w.sa = SRC_XL; w.sb = SRC_LPL; w.sub = 1'b1;
         end
         UC_L_MHI: begin
            w.mul = MUL_HI; w.msel = MSEL_COEFF;
         end
         UC_L_MLO: begin
            w.mul = MUL_LO; w.msel = MSEL_COEFF;
         end
         UC_L_UPD: begin
            w.dst = DST_LPL; w.sa = SRC_LPL; w.sb = SRC_ACC; w.shift = SHIFT_COEFF;
         end
         UC_R_DIFF: begin
            w.dst = DST_A; w.sa = SRC_XR; w.sb = SRC_LPR; w.sub = 1'b1;
         end
         UC_R_MHI: begin
            w.mul = MUL_HI; w.msel = MSEL_COEFF;
         end
         UC_R_MLO: begin
            w.mul = MUL_LO; w.msel = MSEL_COEFF;
         end
         UC_R_UPD: begin
            w.dst = DST_LPR; w.sa = SRC_LPR; w.sb = SRC_ACC; w.shift = SHIFT_COEFF;
         end
         UC_SL: begin
            w.dst = DST_A; w.sa = SRC_LPL; w.sb = SRC_LPR; w.sub = 1'b1;
         end
         UC_SL_MHI: begin
            w.mul = MUL_HI; w.msel = MSEL_WLO;
         end
         UC_SL_MLO: begin
            w.mul = MUL_LO; w.msel = MSEL_WLO;
         end
         UC_TL: begin
            w.dst = DST_SUM; w.sa = SRC_ZERO; w.sb = SRC_ACC; w.shift = SHIFT_WIDTH;
         end
         UC_SH_A: begin
            w.dst = DST_A; w.sa = SRC_XL; w.sb = SRC_XR; w.sub = 1'b1;
         end
         UC_SH_B: begin
            w.dst = DST_A; w.sa = SRC_A; w.sb = SRC_LPL; w.sub = 1'b1;
         end
         UC_SH_C: begin
            w.dst = DST_A; w.sa = SRC_A; w.sb = SRC_LPR;
         end
         UC_SH_MHI: begin
            w.mul = MUL_HI; w.msel = MSEL_WHI;
         end
         UC_SH_MLO: begin
            w.mul = MUL_LO; w.msel = MSEL_WHI;
         end
         UC_TH: begin
            w.dst = DST_SUM; w.sa = SRC_SUM; w.sb = SRC_ACC; w.shift = SHIFT_WIDTH;
         end
         UC_BASE: begin
            w.dst = DST_A; w.sa = SRC_XL; w.sb = SRC_XR;
         end
         UC_FIN_L: begin
            w.fin = FIN_LEFT;
         end
         UC_FIN_R: begin
            w.fin = FIN_RIGHT;
         end
         UC_EMIT: begin
            w.cond = COND_RSP; w.target = UC_IDLE;
         end
         default: begin
            w.target = UC_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/two_band_stereo_width_unit.sv =====
// top level of the two band mid/side stereo width unit
`timescale 1ns / 1ps

// usage
// - req channel: one stereo pair per word (req_word.left_in, req_word.right_in),
//   valid/ready; the unit takes a word only when its program sits at the idle step
// - rsp channel: one widened, saturated stereo pair per request word, valid/ready,
//   held in an output register until taken
// - csr channel: register index and 16-bit data; always ready; index 0 is the
//   crossover coefficient, 1 the low band width, 2 the high band width, others ignored
// - program: the 23-step microcode program runs both lowpass updates and both
//   width products through one split multiplier (two passes per product); a
//   new request word is taken only once the program is back at its idle step
// - when the receiver stalls, the finished word waits in the output register; the
//   next request is still taken and computed, and the program holds at its last
//   step until the output register frees up
// - reset: synchronous, clears the lowpass state and the output valid, loads the
//   register defaults and puts the program at the idle step
module two_band_stereo_width_unit import tbsw_pkg::*; #(
   parameter int COEFF_BITS = COEFF_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_word_type              req_word,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_word_type              rsp_word,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   // configuration registers
   logic [CSR_DATA_BITS-1:0] coeff_ff, coeff_in;
   logic [CSR_DATA_BITS-1:0] wlo_ff, wlo_in;
   logic [CSR_DATA_BITS-1:0] whi_ff, whi_in;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   seq_ctrl_type seq_ctrl;
   rsp_word_type result;
   logic         out_free;
   logic         csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      coeff_in = coeff_ff;
      wlo_in   = wlo_ff;
      whi_in   = whi_ff;
      if (csr_write) begin
         case (csr_index)
            REG_COEFF:      coeff_in = csr_data;
            REG_WIDTH_LOW:  wlo_in   = csr_data;
            REG_WIDTH_HIGH: whi_in   = csr_data;
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff <= COEFF_RESET;
         wlo_ff   <= WIDTH_RESET;
         whi_ff   <= WIDTH_RESET;
      end else begin
         coeff_ff <= coeff_in;
         wlo_ff   <= wlo_in;
         whi_ff   <= whi_in;
      end
   end

   // output slot is free if empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   tbsw_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .seq_ctrl  (seq_ctrl)
   );

   tbsw_datapath #(
      .COEFF_BITS (COEFF_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .seq_ctrl   (seq_ctrl),
      .req_word   (req_word),
      .coeff      (coeff_ff),
      .width_low  (wlo_ff),
      .width_high (whi_ff),
      .result     (result)
   );

   // ready follows the program step alone
   assign req_ready = (seq_ctrl.uword.cond == COND_REQ);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (seq_ctrl.emit) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // program never takes two words back to back
   a_no_double_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken on two consecutive cycles");

   // a word going into the output register shows up as valid
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      seq_ctrl.emit |=> rsp_valid_ff)
      else $error("emitted word not valid on the output");

   // output valid only rises from an emit
   a_rise_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(seq_ctrl.emit))
      else $error("output valid rose without an emit");

   // no request is taken in the same cycle as a result is emitted
   a_take_emit_apart: assert property (@(posedge clock) disable iff (reset)
      !(seq_ctrl.load && seq_ctrl.emit))
      else $error("take and emit in the same step");

endmodule

// ===== hdl/tbsw_sequencer.sv =====
// step counter and control store walk for the stereo width unit
`timescale 1ns / 1ps

module tbsw_sequencer import tbsw_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         out_free,
   output seq_ctrl_type seq_ctrl
);

   logic [PC_BITS-1:0] pc_ff;
   logic [PC_BITS-1:0] pc_in;
   ucode_word_type     uword;
   logic               cond_met;

   assign uword = ucode_rom(pc_ff);

   always_comb begin
      case (uword.cond)
         COND_NEXT: cond_met = 1'b1;
         COND_REQ:  cond_met = req_valid;
         COND_RSP:  cond_met = out_free;
         default:   cond_met = 1'b1;
      endcase
   end

   // hold the step until its condition is met
   assign pc_in = cond_met ? uword.target : pc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= UC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign seq_ctrl.uword = uword;
   assign seq_ctrl.load  = (uword.cond == COND_REQ) && req_valid;
   assign seq_ctrl.emit  = (uword.cond == COND_RSP) && out_free;

endmodule

// ===== hdl/tbsw_datapath.sv =====
// registers, adder, split multiplier and output rounding for the stereo width unit
`timescale 1ns / 1ps

module tbsw_datapath import tbsw_pkg::*; #(
   parameter int COEFF_BITS = COEFF_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  seq_ctrl_type             seq_ctrl,
   input  req_word_type             req_word,
   input  logic [CSR_DATA_BITS-1:0] coeff,
   input  logic [CSR_DATA_BITS-1:0] width_low,
   input  logic [CSR_DATA_BITS-1:0] width_high,
   output rsp_word_type             result
);

   localparam int AW  = SAMPLE_BITS + COEFF_BITS + 3;
   localparam int BW  = (COEFF_BITS > CSR_DATA_BITS) ? COEFF_BITS : CSR_DATA_BITS;
   localparam int LOW = AW / 2;
   localparam int HW  = AW - LOW;
   localparam int PW  = AW + BW + 1;
   localparam int TW  = AW + 2;
   localparam int RW  = TW - COEFF_BITS - 1;
   localparam int XPAD = AW - SAMPLE_BITS - COEFF_BITS;
   localparam logic [CSR_DATA_BITS-1:0] COEFF_MASK = (COEFF_BITS >= CSR_DATA_BITS) ?
      {CSR_DATA_BITS{1'b1}} : CSR_DATA_BITS'((1 << COEFF_BITS) - 1);
   localparam logic signed [RW-1:0] SAT_HI = RW'(SAMPLE_MAX);
   localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;

   function automatic logic [CSR_DATA_BITS-1:0] clamp_width(
      input logic [CSR_DATA_BITS-1:0] w);
      return (w > WIDTH_MAX) ? WIDTH_MAX : w;
   endfunction

   ucode_word_type uw;

   logic signed [AW-1:0] xl_ff, xr_ff, lpl_ff, lpr_ff, a_ff, sum_ff;
   logic signed [AW-1:0] xl_in, xr_in, lpl_in, lpr_in, a_in, sum_in;
   logic signed [PW-1:0] acc_ff, acc_in;
   logic signed [SAMPLE_BITS-1:0] out_l_ff, out_r_ff, out_l_in, out_r_in;

   logic signed [AW-1:0] opa, opb, alu_res, acc_sh;
   logic signed [PW-1:0] acc_shifted;
   logic [BW-1:0]        b_sel;
   logic signed [HW+BW:0]    prod_hi;
   logic signed [LOW+BW+1:0] prod_lo;
   logic signed [TW-1:0] base, twice_t, total, rounded;
   logic signed [RW-1:0] rnd;
   logic signed [SAMPLE_BITS-1:0] sat;

   assign uw = seq_ctrl.uword;

   // operand sources
   assign acc_shifted = (uw.shift == SHIFT_COEFF) ? (acc_ff >>> COEFF_BITS)
                                                  : (acc_ff >>> WIDTH_FRAC);
   assign acc_sh = acc_shifted[AW-1:0];

   always_comb begin
      case (uw.sa)
         SRC_XL:  opa = xl_ff;
         SRC_XR:  opa = xr_ff;
         SRC_LPL: opa = lpl_ff;
         SRC_LPR: opa = lpr_ff;
         SRC_A:   opa = a_ff;
         SRC_SUM: opa = sum_ff;
         SRC_ACC: opa = acc_sh;
         default: opa = '0;
      endcase
      case (uw.sb)
         SRC_XL:  opb = xl_ff;
         SRC_XR:  opb = xr_ff;
         SRC_LPL: opb = lpl_ff;
         SRC_LPR: opb = lpr_ff;
         SRC_A:   opb = a_ff;
         SRC_SUM: opb = sum_ff;
         SRC_ACC: opb = acc_sh;
         default: opb = '0;
      endcase
   end

   assign alu_res = uw.sub ? (opa - opb) : (opa + opb);

   // multiplier operand b, always unsigned
   always_comb begin
      case (uw.msel)
         MSEL_COEFF: b_sel = BW'(coeff & COEFF_MASK);
         MSEL_WLO:   b_sel = BW'(clamp_width(width_low));
         MSEL_WHI:   b_sel = BW'(clamp_width(width_high));
         default:    b_sel = '0;
      endcase
   end

   // a split into signed upper half and unsigned lower half
   assign prod_hi = $signed(a_ff[AW-1:LOW]) * $signed({1'b0, b_sel});
   assign prod_lo = $signed({1'b0, a_ff[LOW-1:0]}) * $signed({1'b0, b_sel});

   always_comb begin
      case (uw.mul)
         MUL_HI:  acc_in = $signed(PW'(prod_hi)) <<< LOW;
         MUL_LO:  acc_in = acc_ff + PW'(prod_lo);
         default: acc_in = acc_ff;
      endcase
   end

   // round half up, then saturate to the sample range
   assign base    = {{2{a_ff[AW-1]}}, a_ff};
   assign twice_t = {sum_ff[AW-1], sum_ff, 1'b0};
   assign total   = (uw.fin == FIN_RIGHT) ? (base - twice_t) : (base + twice_t);
   assign rounded = total + (TW'(1) <<< COEFF_BITS);
   assign rnd     = rounded[TW-1:COEFF_BITS+1];

   always_comb begin
      if (rnd > SAT_HI) begin
         sat = SAT_HI[SAMPLE_BITS-1:0];
      end else if (rnd < SAT_LO) begin
         sat = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
         sat = rnd[SAMPLE_BITS-1:0];
      end
   end

   // register updates
   always_comb begin
      xl_in    = xl_ff;
      xr_in    = xr_ff;
      lpl_in   = lpl_ff;
      lpr_in   = lpr_ff;
      a_in     = a_ff;
      sum_in   = sum_ff;
      out_l_in = out_l_ff;
      out_r_in = out_r_ff;
      if (seq_ctrl.load) begin
         xl_in = {{XPAD{req_word.left_in[SAMPLE_BITS-1]}}, req_word.left_in,
                  {COEFF_BITS{1'b0}}};
         xr_in = {{XPAD{req_word.right_in[SAMPLE_BITS-1]}}, req_word.right_in,
                  {COEFF_BITS{1'b0}}};
      end
      case (uw.dst)
         DST_A:   a_in   = alu_res;
         DST_LPL: lpl_in = alu_res;
         DST_LPR: lpr_in = alu_res;
         DST_SUM: sum_in = alu_res;
         default: ;
      endcase
      case (uw.fin)
         FIN_LEFT:  out_l_in = sat;
         FIN_RIGHT: out_r_in = sat;
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lpl_ff <= '0;
         lpr_ff <= '0;
      end else begin
         lpl_ff <= lpl_in;
         lpr_ff <= lpr_in;
      end
   end

   always_ff @(posedge clock) begin
      xl_ff    <= xl_in;
      xr_ff    <= xr_in;
      a_ff     <= a_in;
      sum_ff   <= sum_in;
      acc_ff   <= acc_in;
      out_l_ff <= out_l_in;
      out_r_ff <= out_r_in;
   end

   assign result.left_out  = out_l_ff;
   assign result.right_out = out_r_ff;

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for the two band stereo width unit
`timescale 1ns / 1ps

module tb;
   import tbsw_pkg::*;

   // fraction bits of the lowpass state, matches the unit's default build
   localparam int CB              = COEFF_BITS_DEF;
   // idle cycles after the last result before a register write or the end
   localparam int SETTLE_CYCLES   = 30;
   // far above the slowest legal run
   localparam int CYCLE_LIMIT     = 400000;
   localparam int RANDOM_PHASES   = 9;
   localparam int WORDS_PER_PHASE = 100;
   localparam int REPORT_LIMIT    = 10;

   localparam int PEAK_POS = SAMPLE_MAX;
   localparam int PEAK_NEG = -SAMPLE_MAX - 1;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_word_type              req_word = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_word_type              rsp_word;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   // stereo pairs waiting to go out, widened pairs waiting to come back
   req_word_type pair_q[$];
   rsp_word_type widened_q[$];
   // words queued but not yet taken by the unit
   int           words_open = 0;
   int           fault_count = 0;
   int           cycle_count = 0;

   // idle odds in percent per cycle, set per phase
   int           send_gap_pct = 0;
   int           recv_gap_pct = 0;
   // sender holds off until every widened pair is back
   bit           draining = 1'b0;

   // local copy of the unit's registers and lowpass state
   logic [CSR_DATA_BITS-1:0] cfg_coeff      = COEFF_RESET;
   logic [CSR_DATA_BITS-1:0] cfg_width_low  = WIDTH_RESET;
   logic [CSR_DATA_BITS-1:0] cfg_width_high = WIDTH_RESET;
   longint                   lp_left  = 0;
   longint                   lp_right = 0;

   // last random pair, reused so the lowpass can settle on steady input
   req_word_type             last_pair = '0;

   two_band_stereo_width_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // floor(a * b / 2^s); all products here stay well inside 64 bits
   function automatic longint floor_mul(input longint a, input longint b, input int s);
      return (a * b) >>> s;
   endfunction

   // side gains above unity act as full width
   function automatic longint clamp_width(input logic [CSR_DATA_BITS-1:0] v);
      return (v > WIDTH_MAX) ? longint'(WIDTH_MAX) : longint'(v);
   endfunction

   // round half up, drop the fraction and the halving, saturate to the sample range
   function automatic logic signed [SAMPLE_BITS-1:0] round_sat(input longint total);
      longint r;
      r = (total + (longint'(1) << CB)) >>> (CB + 1);
      if (r > PEAK_POS) r = PEAK_POS;
      if (r < PEAK_NEG) r = PEAK_NEG;
      return r[SAMPLE_BITS-1:0];
   endfunction

   // advance both lowpass filters by one pair and form the widened output pair
   function automatic rsp_word_type widen_pair(input req_word_type w);
      longint       xl, xr, coeff, sl, sh, tl, th, base;
      rsp_word_type r;
      xl    = longint'($signed(w.left_in)) * (longint'(1) << CB);
      xr    = longint'($signed(w.right_in)) * (longint'(1) << CB);
      coeff = longint'(cfg_coeff) & ((longint'(1) << CB) - 1);
      lp_left  = lp_left + floor_mul(xl - lp_left, coeff, CB);
      lp_right = lp_right + floor_mul(xr - lp_right, coeff, CB);
      // low band side from the lowpass, high band side from what is left over
      sl   = lp_left - lp_right;
      sh   = (xl - lp_left) - (xr - lp_right);
      tl   = floor_mul(sl, clamp_width(cfg_width_low), WIDTH_FRAC);
      th   = floor_mul(sh, clamp_width(cfg_width_high), WIDTH_FRAC);
      base = xl + xr;
      r.left_out  = round_sat(base + 2 * tl + 2 * th);
      r.right_out = round_sat(base - 2 * tl - 2 * th);
      return r;
   endfunction

   function automatic req_word_type make_pair(input int l, input int r);
      req_word_type w;
      w.left_in  = SAMPLE_BITS'(l);
      w.right_in = SAMPLE_BITS'(r);
      return w;
   endfunction

   function automatic int pick_edge();
      case ($urandom_range(4))
         0: begin
            return PEAK_POS;
         end
         1: begin
            return PEAK_NEG;
         end
         2: begin
            return 0;
         end
         3: begin
            return -1;
         end
         default: begin
            return 1;
         end
      endcase
   endfunction

   // mostly full range noise, plus extremes, mono, anti-phase, small and held pairs
   function automatic req_word_type random_pair();
      req_word_type w;
      case ($urandom_range(9))
         0: begin
            w = make_pair(pick_edge(), pick_edge());
         end
         1: begin
            w.left_in  = SAMPLE_BITS'($urandom());
            w.right_in = w.left_in;
         end
         2: begin
            w.left_in  = SAMPLE_BITS'($urandom());
            w.right_in = -w.left_in;
         end
         3: begin
            w = make_pair(int'($urandom_range(511)) - 256, int'($urandom_range(511)) - 256);
         end
         4: begin
            w = last_pair;
         end
         default: begin
            w.left_in  = SAMPLE_BITS'($urandom());
            w.right_in = SAMPLE_BITS'($urandom());
         end
      endcase
      last_pair = w;
      return w;
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] random_width();
      case ($urandom_range(7))
         0: begin
            return CSR_DATA_BITS'($urandom_range(65535, 32769));
         end
         1: begin
            return WIDTH_MAX;
         end
         2: begin
            return '0;
         end
         default: begin
            return CSR_DATA_BITS'($urandom_range(32768));
         end
      endcase
   endfunction

   task automatic note_fault(input string msg);
      fault_count++;
      if (fault_count <= REPORT_LIMIT) $display("%s", msg);
   endtask

   task automatic queue_pair(input req_word_type w);
      pair_q.push_back(w);
      words_open++;
   endtask

   // one register write; the local copy follows at the accepting edge
   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_COEFF: begin
            cfg_coeff = data;
         end
         REG_WIDTH_LOW: begin
            cfg_width_low = data;
         end
         REG_WIDTH_HIGH: begin
            cfg_width_high = data;
         end
         default: begin
            // unknown index leaves every register alone
         end
      endcase
      csr_valid <= 1'b0;
   endtask

   // wait until the unit has taken every word and returned every pair
   task automatic settle();
      while (words_open != 0 || widened_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // request driver: predicts at the accepting edge, then offers the next word
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            widened_q.push_back(widen_pair(req_word));
            words_open--;
         end
         // a word still on offer stays as it is
         if (!(req_valid && !req_ready)) begin
            if (draining && widened_q.size() == 0) draining = 1'b0;
            if (!draining && pair_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               // now and then hold off until the unit has drained completely
               if (send_gap_pct != 0 && $urandom_range(63) == 0) begin
                  draining = 1'b1;
                  req_valid <= 1'b0;
               end else begin
                  req_word  <= pair_q.pop_front();
                  req_valid <= 1'b1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor: compares each taken word against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (widened_q.size() == 0) begin
               note_fault($sformatf("unexpected result word: left %0d right %0d",
                                    rsp_word.left_out, rsp_word.right_out));
            end else begin
               if (rsp_word.left_out !== widened_q[0].left_out)
                  note_fault($sformatf("left_out mismatch: expected %0d, actual %0d",
                                       widened_q[0].left_out, rsp_word.left_out));
               if (rsp_word.right_out !== widened_q[0].right_out)
                  note_fault($sformatf("right_out mismatch: expected %0d, actual %0d",
                                       widened_q[0].right_out, rsp_word.right_out));
               void'(widened_q.pop_front());
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_gap_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // sequencer: reset, directed phases, then random phases
   initial begin
      int phase;
      int n;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // sender idles 30 percent, receiver 61 percent
      send_gap_pct = 30;
      recv_gap_pct = 61;

      // reset defaults: silence, both rails, opposite rails, a small anti-phase pair
      queue_pair(make_pair(0, 0));
      queue_pair(make_pair(PEAK_POS, PEAK_POS));
      queue_pair(make_pair(PEAK_NEG, PEAK_NEG));
      queue_pair(make_pair(PEAK_POS, PEAK_NEG));
      queue_pair(make_pair(PEAK_NEG, PEAK_POS));
      queue_pair(make_pair(1, -1));
      settle();

      // coefficient zero freezes the lowpass, low width far above unity, no high band side
      csr_write(REG_COEFF, '0);
      csr_write(REG_WIDTH_LOW, 16'hFFFF);
      csr_write(REG_WIDTH_HIGH, '0);
      queue_pair(make_pair(PEAK_POS, PEAK_NEG));
      queue_pair(make_pair(12345, -54321));
      queue_pair(make_pair(PEAK_NEG, PEAK_NEG));
      queue_pair(make_pair(-1, 0));
      queue_pair(make_pair(PEAK_POS, PEAK_POS));
      settle();

      // fastest lowpass, no low band side, full high band side
      csr_write(REG_COEFF, 16'hFFFF);
      csr_write(REG_WIDTH_LOW, '0);
      csr_write(REG_WIDTH_HIGH, WIDTH_MAX);
      queue_pair(make_pair(PEAK_NEG, PEAK_POS));
      queue_pair(make_pair(PEAK_POS, PEAK_NEG));
      queue_pair(make_pair(PEAK_POS, PEAK_NEG));
      queue_pair(make_pair(0, 0));
      queue_pair(make_pair(4000000, -4000000));
      settle();

      // unknown indexes are dropped, slowest nonzero lowpass, low width just past unity, high width far above it
      csr_write(CSR_INDEX_BITS'(3), 16'h1234);
      csr_write(CSR_INDEX_BITS'(255), 16'hFFFF);
      csr_write(REG_COEFF, 16'd1);
      csr_write(REG_WIDTH_LOW, 16'd32769);
      csr_write(REG_WIDTH_HIGH, 16'hFFFF);
      queue_pair(make_pair(PEAK_POS, PEAK_NEG));
      queue_pair(make_pair(PEAK_NEG, PEAK_POS));
      queue_pair(make_pair(100, -100));
      queue_pair(make_pair(PEAK_POS, 0));
      queue_pair(make_pair(0, PEAK_NEG));

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         // swap the idle odds after a third, then run without idling
         if (phase == RANDOM_PHASES / 3) begin
            send_gap_pct = 61;
            recv_gap_pct = 30;
         end else if (phase == 2 * RANDOM_PHASES / 3) begin
            send_gap_pct = 0;
            recv_gap_pct = 0;
         end
         settle();
         case ($urandom_range(3))
            0: begin
               csr_write(REG_COEFF, CSR_DATA_BITS'($urandom_range(2000, 1)));
            end
            1: begin
               csr_write(REG_COEFF, 16'hFFFF);
            end
            default: begin
               csr_write(REG_COEFF, CSR_DATA_BITS'($urandom()));
            end
         endcase
         csr_write(REG_WIDTH_LOW, random_width());
         csr_write(REG_WIDTH_HIGH, random_width());
         if ($urandom_range(3) == 0)
            csr_write(CSR_INDEX_BITS'($urandom_range(255, 3)), CSR_DATA_BITS'($urandom()));
         for (n = 0; n < WORDS_PER_PHASE; n++) queue_pair(random_pair());
      end

      settle();
      if (widened_q.size() != 0)
         note_fault($sformatf("%0d result words never arrived", widened_q.size()));
      if (fault_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/tbsw_pkg.sv
hdl/tbsw_sequencer.sv
hdl/tbsw_datapath.sv
hdl/two_band_stereo_width_unit.sv
dv/tb.sv
